// ===== design/tle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_pkg
// constants, types and the control store of the terminal line editor
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int LINE_MAX   = 32;
   localparam int LINE_AW    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int CNT_W      = $clog2(LINE_MAX + 1);
   localparam int PROMPT_LEN = 17;
   localparam int PROMPT_AW  = $clog2(PROMPT_LEN);
   localparam int IDX_W      = (LINE_AW > PROMPT_AW) ? LINE_AW : PROMPT_AW;
   localparam int ESC_SPAN   = 4;
   localparam int SKIP_W     = $clog2(ESC_SPAN);

   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_SP  = 8'h20;

   localparam logic KIND_ECHO = 1'b0;
   localparam logic KIND_LINE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BS_SP,
      S_BS_BS,
      S_L_RD,
      S_L_EM,
      S_L_CR,
      S_L_NUL,
      S_P_EM
   } step_type;

   typedef enum logic [1:0] {
      SRC_CONST,
      SRC_STORE,
      SRC_PROMPT
   } src_type;

   typedef enum logic [1:0] {
      LAST_NO,
      LAST_YES,
      LAST_NO_ECHO,
      LAST_PROMPT_END
   } last_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_INC,
      IDX_CLEAR
   } idx_op_type;

   typedef enum logic [2:0] {
      JC_ALWAYS,
      JC_NEVER,
      JC_DISPATCH,
      JC_LINE_MORE,
      JC_ECHO,
      JC_PROMPT_MORE
   } cond_type;

   typedef struct packed {
      logic       emit;
      logic       kind;
      src_type    src;
      logic [7:0] const_byte;
      last_type   last_sel;
      idx_op_type idx_op;
      logic       read_req;
      logic       clear_count;
      cond_type   cond;
      step_type   tgt_true;
      step_type   tgt_false;
   } ucode_word_type;

   typedef struct packed {
      step_type       step;
      ucode_word_type word;
      logic           adv;
      logic           accept;
   } ctrl_type;

   typedef struct packed {
      logic out_free;
      logic bs_go;
      logic line_go;
      logic prompt_go;
      logic line_more;
      logic prompt_more;
      logic echo;
   } stat_type;

   function automatic ucode_word_type ucode_rom(input step_type s);
      ucode_word_type w;
      w = '0;
      w.src       = SRC_CONST;
      w.last_sel  = LAST_NO;
      w.idx_op    = IDX_HOLD;
      w.cond      = JC_NEVER;
      w.tgt_true  = S_IDLE;
      w.tgt_false = S_IDLE;
      unique case (s)
         S_IDLE: begin
            w.cond = JC_DISPATCH;
         end
         S_BS_SP: begin
            w.emit       = 1'b1;
            w.kind       = KIND_ECHO;
            w.const_byte = CH_SP;
            w.cond       = JC_ALWAYS;
            w.tgt_true   = S_BS_BS;
         end
         S_BS_BS: begin
            w.emit       = 1'b1;
            w.kind       = KIND_ECHO;
            w.const_byte = CH_BS;
            w.last_sel   = LAST_YES;
         end
         S_L_RD: begin
            w.read_req = 1'b1;
            w.cond     = JC_ALWAYS;
            w.tgt_true = S_L_EM;
         end
         S_L_EM: begin
            w.emit      = 1'b1;
            w.kind      = KIND_LINE;
            w.src       = SRC_STORE;
            w.idx_op    = IDX_INC;
            w.cond      = JC_LINE_MORE;
            w.tgt_true  = S_L_RD;
            w.tgt_false = S_L_CR;
         end
         S_L_CR: begin
            w.emit       = 1'b1;
            w.kind       = KIND_LINE;
            w.const_byte = CH_CR;
            w.cond       = JC_ALWAYS;
            w.tgt_true   = S_L_NUL;
         end
         S_L_NUL: begin
            w.emit        = 1'b1;
            w.kind        = KIND_LINE;
            w.const_byte  = CH_NUL;
            w.last_sel    = LAST_NO_ECHO;
            w.idx_op      = IDX_CLEAR;
            w.clear_count = 1'b1;
            w.cond        = JC_ECHO;
            w.tgt_true    = S_P_EM;
         end
         S_P_EM: begin
            w.emit     = 1'b1;
            w.kind     = KIND_ECHO;
            w.src      = SRC_PROMPT;
            w.last_sel = LAST_PROMPT_END;
            w.idx_op   = IDX_INC;
            w.cond     = JC_PROMPT_MORE;
            w.tgt_true = S_P_EM;
         end
         default: begin
            w.cond = JC_NEVER;
         end
      endcase
      return w;
   endfunction

   // crlf, colour set, "@> ", colour reset
   function automatic logic [7:0] prompt_rom(input logic [IDX_W-1:0] i);
      logic [7:0] b;
      case (i)
         IDX_W'(0):  b = 8'h0D;
         IDX_W'(1):  b = 8'h0A;
         IDX_W'(2):  b = 8'h1B;
         IDX_W'(3):  b = 8'h5B;
         IDX_W'(4):  b = 8'h33;
         IDX_W'(5):  b = 8'h34;
         IDX_W'(6):  b = 8'h3B;
         IDX_W'(7):  b = 8'h34;
         IDX_W'(8):  b = 8'h30;
         IDX_W'(9):  b = 8'h6D;
         IDX_W'(10): b = 8'h40;
         IDX_W'(11): b = 8'h3E;
         IDX_W'(12): b = 8'h20;
         IDX_W'(13): b = 8'h1B;
         IDX_W'(14): b = 8'h5B;
         IDX_W'(15): b = 8'h30;
         IDX_W'(16): b = 8'h6D;
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== design/tle_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle channels
// valid/ready channels for received bytes and for result beats
// ----------------------------------------------------------------------------
interface tle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_kind, output out_byte, output out_last,
                   input ready);
   modport sink   (input valid, input out_kind, input out_byte, input out_last,
                   output ready);
endinterface

// ===== design/terminal_line_editor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_unit
// line editor for bytes typed at a host terminal
// ----------------------------------------------------------------------------
// req_bus takes one received byte per beat; rsp_bus gives result beats, each
// an echo byte (out_kind 0) or a byte of a finished line (out_kind 1), with
// out_last on the final beat caused by one received byte.
// csr_wr_en / csr_wr_data write the echo enable bit (1 after reset).
// an ordinary byte or a dropped escape byte is taken from the idle step; an
// ordinary byte's echo beat is in the result register in the next cycle.
// a backspace is taken with its first echo beat, then runs S_BS_SP and S_BS_BS.
// a line end takes the byte, then per stored byte a registered read of the line
// memory and then the beat, then cr and nul, and the prompt when echo is on.
// the step counter walks a small control program and takes a new byte only
// from its idle step, with the result register free or draining.
// reset clears the line count, escape skip and result valid and sets echo on.
// a stalled receiver holds the result register, and the step counter waits at
// the next step that emits a beat or takes a byte; no beat is dropped and input waits.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit
   import tle_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   tle_req_if.sink  req_bus,
   tle_rsp_if.source rsp_bus,
   input  logic     csr_wr_en,
   input  logic     csr_wr_data
);

   ctrl_type ctrl;
   stat_type stat;

   tle_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   tle_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .rx_byte     (req_bus.rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .out_kind    (rsp_bus.out_kind),
      .out_byte    (rsp_bus.out_byte),
      .out_last    (rsp_bus.out_last)
   );

   // input only taken in the idle step
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (ctrl.step == S_IDLE))
      else $error("input ready outside idle step");

   // an escape byte starts no routine
   a_esc_idle: assert property (@(posedge clock) disable iff (reset)
      (ctrl.accept && (req_bus.rx_byte == CH_ESC)) |=> (ctrl.step == S_IDLE))
      else $error("escape byte left idle step");

   // line end on a non-empty line starts the line read-out
   a_line_start: assert property (@(posedge clock) disable iff (reset)
      (ctrl.accept && stat.line_go) |=> (ctrl.step == S_L_RD))
      else $error("line read-out not started");

   // final prompt beat carries the last flag
   a_prompt_last: assert property (@(posedge clock) disable iff (reset)
      ((ctrl.step == S_P_EM) && ctrl.adv && !stat.prompt_more)
         |=> (rsp_bus.valid && rsp_bus.out_last))
      else $error("prompt end without last flag");

endmodule

// ===== design/tle_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_line_store
// line buffer memory, one write and one registered read port
// ----------------------------------------------------------------------------
module tle_line_store
   import tle_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [LINE_AW-1:0] wr_addr,
   input  logic [7:0]         wr_data,
   input  logic               rd_en,
   input  logic [LINE_AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] store_mem [LINE_MAX];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tle_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_sequencer
// step counter over the control store, with dispatch and conditional jumps
// ----------------------------------------------------------------------------
module tle_sequencer
   import tle_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   step_type       step_ff;
   step_type       step_in;
   ucode_word_type word;
   logic           cond_true;
   logic           dispatch;
   logic           accept;
   logic           adv;

   always_comb begin
      word      = ucode_rom(step_ff);
      dispatch  = (word.cond == JC_DISPATCH);
      req_ready = dispatch && stat.out_free;
      accept    = req_valid && req_ready;
      adv       = dispatch ? accept : (!word.emit || stat.out_free);
   end

   always_comb begin
      unique case (word.cond)
         JC_ALWAYS:      cond_true = 1'b1;
         JC_NEVER:       cond_true = 1'b0;
         JC_DISPATCH:    cond_true = 1'b0;
         JC_LINE_MORE:   cond_true = stat.line_more;
         JC_ECHO:        cond_true = stat.echo;
         JC_PROMPT_MORE: cond_true = stat.prompt_more;
         default:        cond_true = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      step_in = step_ff;
      if (adv) begin
         if (dispatch) begin
            if (stat.bs_go) begin
               step_in = S_BS_SP;
            end else if (stat.line_go) begin
               step_in = S_L_RD;
            end else if (stat.prompt_go) begin
               step_in = S_P_EM;
            end else begin
               step_in = S_IDLE;
            end
         end else begin
            step_in = cond_true ? word.tgt_true : word.tgt_false;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // control outputs
   always_comb begin
      ctrl.step   = step_ff;
      ctrl.word   = word;
      ctrl.adv    = adv;
      ctrl.accept = accept;
   end

endmodule

// ===== design/tle_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_datapath
// byte decode, line count, escape skip, index counter and result register
// ----------------------------------------------------------------------------
module tle_datapath
   import tle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  ctrl_type   ctrl,
   input  logic [7:0] rx_byte,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output stat_type   stat,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       out_kind,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [SKIP_W-1:0] skip_ff,   skip_in;
   logic [IDX_W-1:0]  idx_ff,    idx_in;
   logic              echo_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              kind_ff,   kind_in;
   logic [7:0]        byte_ff,   byte_in;
   logic              last_ff,   last_in;

   logic [CNT_W-1:0]  cnt_eff;
   logic [CNT_W:0]    idx_next;
   logic              is_esc, is_bs, is_eol, skipping, live, ord;
   logic              bs_go, line_go, prompt_go;
   logic              out_free, load, acc_emit, seq_emit;
   logic              mem_we, mem_re;
   logic [7:0]        rd_data;
   logic              seq_last;
   logic [7:0]        seq_byte;

   tle_line_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (cnt_eff[LINE_AW-1:0]),
      .wr_data (rx_byte),
      .rd_en   (mem_re),
      .rd_addr (idx_ff[LINE_AW-1:0]),
      .rd_data (rd_data)
   );

   // byte decode, a full line is dropped before the byte is looked at
   always_comb begin
      cnt_eff   = (count_ff == CNT_W'(LINE_MAX)) ? '0 : count_ff;
      is_esc    = (rx_byte == CH_ESC);
      is_bs     = (rx_byte == CH_BS);
      is_eol    = (rx_byte == CH_CR) || (rx_byte == CH_NUL);
      skipping  = !is_esc && (skip_ff != '0);
      live      = !is_esc && !skipping;
      ord       = live && !is_bs && !is_eol;
      bs_go     = live && is_bs && (cnt_eff != '0) && echo_ff;
      line_go   = live && is_eol && (cnt_eff != '0);
      prompt_go = live && is_eol && (cnt_eff == '0) && echo_ff;
      out_free  = !rsp_valid_ff || rsp_ready;
      idx_next  = (CNT_W+1)'(idx_ff) + (CNT_W+1)'(1);
   end

   always_comb begin
      stat.out_free    = out_free;
      stat.bs_go       = bs_go;
      stat.line_go     = line_go;
      stat.prompt_go   = prompt_go;
      stat.line_more   = idx_next < {1'b0, count_ff};
      stat.prompt_more = (idx_ff != IDX_W'(PROMPT_LEN - 1));
      stat.echo        = echo_ff;
   end

   assign mem_we = ctrl.accept && ord;
   assign mem_re = ctrl.adv && ctrl.word.read_req;

   // line count, skip counter, index
   always_comb begin
      count_in = count_ff;
      skip_in  = skip_ff;
      idx_in   = idx_ff;
      if (ctrl.accept) begin
         idx_in = '0;
         if (ord) begin
            count_in = cnt_eff + CNT_W'(1);
         end else if (bs_go) begin
            count_in = cnt_eff - CNT_W'(1);
         end else begin
            count_in = cnt_eff;
         end
         if (is_esc) begin
            skip_in = SKIP_W'(ESC_SPAN - 1);
         end else if (skipping) begin
            skip_in = skip_ff - SKIP_W'(1);
         end
      end else if (ctrl.adv) begin
         if (ctrl.word.clear_count) begin
            count_in = '0;
         end
         case (ctrl.word.idx_op)
            IDX_INC:   idx_in = idx_ff + IDX_W'(1);
            IDX_CLEAR: idx_in = '0;
            default:   idx_in = idx_ff;
         endcase
      end
   end

   // result beat source
   always_comb begin
      case (ctrl.word.src)
         SRC_STORE:  seq_byte = rd_data;
         SRC_PROMPT: seq_byte = prompt_rom(idx_ff);
         default:    seq_byte = ctrl.word.const_byte;
      endcase
      case (ctrl.word.last_sel)
         LAST_YES:        seq_last = 1'b1;
         LAST_NO_ECHO:    seq_last = !echo_ff;
         LAST_PROMPT_END: seq_last = !stat.prompt_more;
         default:         seq_last = 1'b0;
      endcase
   end

   always_comb begin
      acc_emit     = ctrl.accept && ((ord && echo_ff) || bs_go);
      seq_emit     = ctrl.adv && ctrl.word.emit;
      load         = acc_emit || seq_emit;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (acc_emit) begin
         kind_in = KIND_ECHO;
         byte_in = ord ? rx_byte : CH_BS;
         last_in = ord;
      end else if (seq_emit) begin
         kind_in = ctrl.word.kind;
         byte_in = seq_byte;
         last_in = seq_last;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         skip_ff      <= '0;
         idx_ff       <= '0;
         echo_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         skip_ff      <= skip_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            echo_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule
